>>> hw/rtl/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg: shared types and constants for the FIR filter
// Item structs, opcodes, cell control and default tap count.
// ----------------------------------------------------------------------------
`default_nettype none

package fir_pkg;

	localparam int TAPS_DEF = 16;
	localparam int SMP_W    = 16;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_LOAD = 1'b1
	} opcode_t;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] sample_in;
		logic [3:0]         coef_index;
		logic signed [15:0] coef_value;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               clipped;
	} out_item_t;

	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/fir_cell.sv
// ----------------------------------------------------------------------------
// fir_cell: one tap of the delay chain
// Holds one sample and one coefficient; shifts samples in on a push and
// rotates sample and coefficient toward the head during accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fir_pkg::cell_ctl_t  ctl,
	input  wire logic                coef_we,
	input  wire logic signed [15:0]  coef_wdata,
	input  wire logic signed [15:0]  left_smp,
	input  wire logic signed [15:0]  right_smp,
	input  wire logic signed [15:0]  right_coef,
	output logic signed [15:0]       smp,
	output logic signed [15:0]       coef
);

	logic signed [15:0] smp_q;
	logic signed [15:0] coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q  <= '0;
			coef_q <= '0;
		end else begin
			if (ctl.shift) begin
				smp_q <= left_smp;
			end else if (ctl.rotate) begin
				smp_q <= right_smp;
			end
			if (ctl.rotate) begin
				coef_q <= right_coef;
			end else if (coef_we) begin
				coef_q <= coef_wdata;
			end
		end
	end

	assign smp  = smp_q;
	assign coef = coef_q;

endmodule

`default_nettype wire

>>> hw/rtl/fir_mac.sv
// ----------------------------------------------------------------------------
// fir_mac: shared multiply-accumulate with rounding and saturation
// Registers each product, accumulates exactly, then rounds half up at bit 15
// and clamps to signed 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_mac #(
	parameter int TAPS = fir_pkg::TAPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clear,
	input  wire logic               en,
	input  wire logic signed [15:0] smp,
	input  wire logic signed [15:0] coef,
	output fir_pkg::out_item_t      result
);

	localparam int ACC_W = 2 * fir_pkg::SMP_W + $clog2(TAPS) + 1;

	localparam logic signed [ACC_W:0] RND  = (ACC_W + 1)'(16384);
	localparam logic signed [ACC_W:0] MAXV = (ACC_W + 1)'(32767);
	localparam logic signed [ACC_W:0] MINV = -(ACC_W + 1)'(32768);

	logic signed [31:0]      prod_s1;
	logic                    vld_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W:0]   acc_x;
	logic signed [ACC_W:0]   shifted;

	always_ff @(posedge clk) begin
		prod_s1 <= smp * coef;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= en;
			if (clear) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	always_comb begin
		acc_x   = (ACC_W + 1)'(acc_q);
		shifted = (acc_x + RND) >>> 15;
		if (shifted > MAXV) begin
			result.sample_out = 16'sh7fff;
			result.clipped    = 1'b1;
		end else if (shifted < MINV) begin
			result.sample_out = 16'sh8000;
			result.clipped    = 1'b1;
		end else begin
			result.sample_out = shifted[15:0];
			result.clipped    = 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/fir_filter.sv
// ----------------------------------------------------------------------------
// fir_filter: direct-form FIR filter, chain of tap cells and one shared MAC
// Loads Q1.15 coefficients and filters signed 16-bit samples.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload                 | direction
//  --------+---------------------+-------------------------+----------
//  in      | in_valid/in_ready   | fir_pkg::in_item_t      | into block
//  out     | out_valid/out_ready | fir_pkg::out_item_t     | out of block
//
//  A coefficient load gives no result and leaves the block idle.
//  A sample push rotates every tap past the single multiplier, then passes a
//  drain state and a final state that rounds and registers the result.
//  Input is ready only in idle, so no new item is taken while a push runs.
//  A waiting result does not block loads; a push holds in its final state until
//  the output register is free. Reset clears all samples and coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter #(
	parameter int TAPS = fir_pkg::TAPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire fir_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output fir_pkg::out_item_t      out_item
);

	localparam int CNT_W = $clog2(TAPS + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic               in_acc;
	logic               push;
	logic               load;
	logic               fin_load;
	fir_pkg::cell_ctl_t ctl;
	fir_pkg::out_item_t result;
	fir_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic signed [15:0] smp  [TAPS];
	logic signed [15:0] coef [TAPS];
	logic [TAPS-1:0]    coef_we;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign push     = in_acc && (in_item.opcode == fir_pkg::OP_PUSH);
	assign load     = in_acc && (in_item.opcode == fir_pkg::OP_LOAD);
	assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	assign ctl.shift  = push;
	assign ctl.rotate = (state_q == S_RUN);

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		logic signed [15:0] left_smp;
		if (k == 0) begin : g_head
			assign left_smp = in_item.sample_in;
		end else begin : g_body
			assign left_smp = smp[k-1];
		end
		assign coef_we[k] = load && (32'(in_item.coef_index) == k);

		fir_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.coef_we    (coef_we[k]),
			.coef_wdata (in_item.coef_value),
			.left_smp   (left_smp),
			.right_smp  (smp[(k + 1) % TAPS]),
			.right_coef (coef[(k + 1) % TAPS]),
			.smp        (smp[k]),
			.coef       (coef[k])
		);
	end

	fir_mac #(
		.TAPS (TAPS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (push),
		.en     (state_q == S_RUN),
		.smp    (smp[0]),
		.coef   (coef[0]),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (push) begin
						state_q <= S_RUN;
						count_q <= '0;
					end
				end
				S_RUN: begin
					count_q <= count_q + 1'b1;
					if (count_q == CNT_W'(TAPS - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTHESIS
	a_push_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (state_q == S_RUN) && (count_q == '0))
		else $error("push did not start accumulation");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) && (count_q == CNT_W'(TAPS - 1)) |=> (state_q == S_DRAIN))
		else $error("accumulation did not end after last tap");

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q == S_IDLE))
		else $error("coefficient load left idle");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result appeared without finishing a push");
`endif

endmodule

`default_nettype wire
